[sv/rfcrsf_pkg.sv]
// Shared types, constants and CRC functions of the RF packet to RC frame encoder.
package rfcrsf_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hA5;
  localparam logic [7:0] CRSF_ADDR = 8'hC8;
  localparam logic [7:0] CRSF_LEN  = 8'd24;
  localparam logic [7:0] CRSF_TYPE = 8'h16;

  localparam logic [3:0] RF_CRC_POS   = 4'd11;
  localparam logic [3:0] CHAN_FIRST   = 4'd3;
  localparam logic [3:0] CHAN_LAST    = 4'd10;
  localparam logic [3:0] POS_MAX      = 4'd15;

  localparam logic [4:0] FRM_TYPE_IDX = 5'd2;
  localparam logic [4:0] FRM_PAY_LAST = 5'd24;
  localparam logic [4:0] FRM_LAST_IDX = 5'd25;

  localparam logic [10:0] CH_MAX     = 11'd2047;
  localparam logic [10:0] CH_MID     = 11'd992;
  localparam logic [10:0] CH_SPAN    = 11'd1984;
  localparam logic [10:0] US_SPAN    = 11'd1000;
  localparam logic [10:0] DEN_RAW    = 11'd2047;
  localparam logic [10:0] DEN_US     = 11'd1000;

  // Reciprocals of the divisors scaled by 2^32 and rounded up; the floor of
  // product >> 32 is exact for every dividend below 2^21.
  localparam logic [22:0] RCP_RAW    = 23'd2098177;
  localparam logic [22:0] RCP_US     = 23'd4294968;

  // Channels 4..15 idle at mid stick; channels 0..3 are filled in later.
  localparam logic [175:0] PAY_INIT = {{12{CH_MID}}, 44'd0};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_STORE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_take;
    logic start;
    logic mul1;
    logic mul2;
    logic div_step;
    logic den_sel;
    logic store_ch;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic pkt_ok;
    logic last_ch;
    logic last_byte;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] rf_crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       mix;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ b[i];
      c = c >> 1;
      if (mix) begin
        c = c ^ 8'h8C;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] crsf_crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = (c << 1) ^ 8'hD5;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

[sv/rfcrsf_ctrl.sv]
// Sequencing state machine: packet intake, channel scaling steps and frame output.
module rfcrsf_ctrl import rfcrsf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && stat.pkt_ok) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_DIV1;
      ST_DIV1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_DIV2;
      ST_DIV2: state_nxt = ST_STORE;
      ST_STORE: begin
        if (stat.last_ch) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MUL1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free && stat.last_byte) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.in_take = in_valid;
        cmd.start   = in_valid && stat.pkt_ok;
      end
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_DIV1: cmd.div_step = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      ST_DIV2: begin
        cmd.div_step = 1'b1;
        cmd.den_sel  = 1'b1;
      end
      ST_STORE: cmd.store_ch = 1'b1;
      ST_EMIT: cmd.emit = stat.out_free;
      default: in_stall = 1'b1;
    endcase
  end

  // A packet start only comes out of idle and leads into the first multiply.
  a_start_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == ST_MUL1)
    else $error("packet start did not enter scaling");

  // Scaling always ends in a store before the next multiply or output.
  a_div2_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV2) |=> state_r == ST_STORE)
    else $error("second divide not followed by store");

endmodule

[sv/rfcrsf_dp.sv]
// Datapath: packet checker, scaling multiplier with reciprocal divide, frame builder.
module rfcrsf_dp import rfcrsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output stat_t      stat,
  input  logic [7:0] in_rf_byte,
  input  logic       in_packet_end,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_frame_byte,
  output logic       out_frame_last
);

  // packet intake
  logic [3:0]  pos_r;
  logic [7:0]  rf_crc_r;
  logic        sync_r;
  logic [15:0] chan_r [4];
  logic [3:0]  chan_ofs;

  // scaling
  logic [20:0] rem_r;
  logic [10:0] quot_r;
  logic [1:0]  ch_idx_r;
  logic [15:0] raw_word;
  logic [10:0] raw_clamp;
  logic [10:0] den;
  logic [22:0] rcp;
  logic [43:0] div_prod;
  logic [10:0] div_q;

  // frame output
  logic [175:0] pay_r;
  logic [7:0]   crsf_crc_r;
  logic [4:0]   byte_idx_r;
  logic [7:0]   cur_byte;
  logic         out_valid_r;
  logic [7:0]   out_byte_r;
  logic         out_last_r;

  assign chan_ofs = pos_r - CHAN_FIRST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      rf_crc_r <= '0;
      sync_r   <= 1'b0;
    end else if (cmd.in_take) begin
      if (in_packet_end) begin
        pos_r    <= '0;
        rf_crc_r <= '0;
        sync_r   <= 1'b0;
      end else begin
        if (pos_r < RF_CRC_POS) begin
          rf_crc_r <= rf_crc_step(rf_crc_r, in_rf_byte);
        end
        if (pos_r == 4'd0) begin
          sync_r <= (in_rf_byte == SYNC_BYTE);
        end
        if (pos_r != POS_MAX) begin
          pos_r <= pos_r + 4'd1;
        end
      end
    end
  end

  // Channel words arrive big-endian: even offset is the high byte.
  always_ff @(posedge clk) begin
    if (cmd.in_take && !in_packet_end && pos_r >= CHAN_FIRST && pos_r <= CHAN_LAST) begin
      if (chan_ofs[0]) begin
        chan_r[chan_ofs[2:1]][7:0] <= in_rf_byte;
      end else begin
        chan_r[chan_ofs[2:1]][15:8] <= in_rf_byte;
      end
    end
  end

  assign stat.pkt_ok = in_packet_end && (pos_r == RF_CRC_POS) && sync_r
                       && (in_rf_byte == rf_crc_r);

  assign raw_word  = chan_r[ch_idx_r];
  assign raw_clamp = (raw_word > 16'(CH_MAX)) ? CH_MAX : raw_word[10:0];
  assign den       = cmd.den_sel ? DEN_US : DEN_RAW;
  assign rcp       = cmd.den_sel ? RCP_US : RCP_RAW;
  assign div_prod  = 44'(rem_r) * 44'(rcp);
  assign div_q     = div_prod[42:32];

  // Divide by multiplying with the scaled reciprocal.
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      rem_r  <= 21'(raw_clamp) * 21'(US_SPAN);
      quot_r <= '0;
    end else if (cmd.mul2) begin
      rem_r  <= 21'(quot_r) * 21'(CH_SPAN);
      quot_r <= '0;
    end else if (cmd.div_step) begin
      quot_r <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_idx_r <= '0;
    end else begin
      if (cmd.start) begin
        ch_idx_r <= '0;
      end else if (cmd.store_ch) begin
        ch_idx_r <= ch_idx_r + 2'd1;
      end
    end
  end

  assign stat.last_ch  = (ch_idx_r == 2'd3);

  always_comb begin
    case (byte_idx_r)
      5'd0:         cur_byte = CRSF_ADDR;
      5'd1:         cur_byte = CRSF_LEN;
      FRM_TYPE_IDX: cur_byte = CRSF_TYPE;
      FRM_LAST_IDX: cur_byte = crsf_crc_r;
      default:      cur_byte = pay_r[7:0];
    endcase
  end

  // Payload bytes leave from the low end; shift after each one.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pay_r <= PAY_INIT;
    end else if (cmd.store_ch) begin
      case (ch_idx_r)
        2'd0:    pay_r[10:0]  <= quot_r;
        2'd1:    pay_r[21:11] <= quot_r;
        2'd2:    pay_r[32:22] <= quot_r;
        default: pay_r[43:33] <= quot_r;
      endcase
    end else if (cmd.emit && byte_idx_r > FRM_TYPE_IDX && byte_idx_r <= FRM_PAY_LAST) begin
      pay_r <= pay_r >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r <= '0;
      crsf_crc_r <= '0;
    end else if (cmd.start) begin
      byte_idx_r <= '0;
      crsf_crc_r <= '0;
    end else if (cmd.emit) begin
      byte_idx_r <= byte_idx_r + 5'd1;
      if (byte_idx_r >= FRM_TYPE_IDX && byte_idx_r <= FRM_PAY_LAST) begin
        crsf_crc_r <= crsf_crc_step(crsf_crc_r, cur_byte);
      end
    end
  end

  assign stat.last_byte = (byte_idx_r == FRM_LAST_IDX);
  assign stat.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= cur_byte;
      out_last_r <= (byte_idx_r == FRM_LAST_IDX);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_last = out_last_r;

  // The reciprocal product gives the exact floor quotient.
  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> ((32'(div_q) * 32'(den) <= 32'(rem_r))
                      && (32'(rem_r) < 32'(div_q) * 32'(den) + 32'(den))))
    else $error("reciprocal divide not exact");

  a_scaled_max: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_ch |-> quot_r <= CH_SPAN)
    else $error("scaled channel above span");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("frame byte overwrote a pending item");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && byte_idx_r == FRM_LAST_IDX) |=> (out_valid_r && out_last_r))
    else $error("final frame byte lost its last flag");

endmodule

[sv/rf_control_packet_to_crsf_rc_frame.sv]
// Top level of the RF control packet to CRSF RC-channels frame encoder.
// Packet bytes are taken one per cycle while the block is idle. A packet that is
// exactly 12 bytes long, starts with 0xA5 and ends with a matching CRC-8 starts
// frame building: the input then stalls while four channels are scaled, each by a
// multiply, a reciprocal divide, a second multiply, a second reciprocal divide and
// a store, followed by 26 frame bytes at one per cycle as the output takes them.
// Input reopens the cycle after the last frame byte is loaded into the output
// register, so an accepted packet holds the input off through all of its scaling
// and frame output, and for as long as the output stalls a pending frame byte.
// Rejected packets produce nothing and leave the input open.
module rf_control_packet_to_crsf_rc_frame import rfcrsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rf_byte,
  input  logic       in_packet_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_frame_last
);

  cmd_t  cmd;
  stat_t stat;

  rfcrsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rfcrsf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_rf_byte     (in_rf_byte),
    .in_packet_end  (in_packet_end),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last)
  );

endmodule

[verif/rf_crsf_frame_checker.sv]
// Checker for the RF packet to RC frame encoder: predicts frames and compares frame bytes.
`timescale 1ns / 100ps

module rf_crsf_frame_checker import rfcrsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rf_byte,
  input  logic       in_packet_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_frame_byte,
  input  logic       out_frame_last,
  output int         failures,
  output int         pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic [3:0]  pkt_count;
  logic [7:0]  pkt_crc;
  logic        sync_ok;
  logic [7:0]  chan_store [8];
  frame_byte_t frame_bytes_due [$];

  // Reflected CRC-8, polynomial 0x8C, LSB of the data first.
  function automatic logic [7:0] rf_check_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ b[i]) ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

  // MSB-first CRC-8, polynomial 0xD5.
  function automatic logic [7:0] frame_crc_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [10:0] scale_stick(input logic [15:0] raw);
    int unsigned v;
    int unsigned us_off;
    int unsigned ch;
    v = (raw > 16'd2047) ? 2047 : raw;
    us_off = (v * 1000) / 2047;
    ch = (us_off * 1984) / 1000;
    if (ch > 1984) begin
      ch = 1984;
    end
    return ch[10:0];
  endfunction

  // Build the 26-byte channels frame from the stored stick words and queue it.
  function automatic void queue_rc_frame();
    logic [175:0] pay;
    logic [7:0]   fb [26];
    logic [7:0]   crc;
    frame_byte_t  item;
    pay = '0;
    for (int i = 0; i < 16; i++) begin
      if (i < 4) begin
        pay[i*11 +: 11] = scale_stick({chan_store[2*i], chan_store[2*i+1]});
      end else begin
        pay[i*11 +: 11] = CH_MID;
      end
    end
    fb[0] = CRSF_ADDR;
    fb[1] = CRSF_LEN;
    fb[2] = CRSF_TYPE;
    for (int j = 0; j < 22; j++) begin
      fb[3+j] = pay[j*8 +: 8];
    end
    crc = 8'h00;
    for (int j = 2; j < 25; j++) begin
      crc = frame_crc_next(crc, fb[j]);
    end
    fb[25] = crc;
    for (int j = 0; j < 26; j++) begin
      item.data = fb[j];
      item.last = (j == 25);
      frame_bytes_due.push_back(item);
    end
  endfunction

  always @(posedge clk) begin : watch
    frame_byte_t due;
    if (!rst_n) begin
      pkt_count = 4'd0;
      pkt_crc = 8'h00;
      sync_ok = 1'b0;
      frame_bytes_due.delete();
      failures = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (!in_packet_end) begin
          if (pkt_count < RF_CRC_POS) begin
            pkt_crc = rf_check_next(pkt_crc, in_rf_byte);
          end
          if (pkt_count == 4'd0) begin
            sync_ok = (in_rf_byte == SYNC_BYTE);
          end
          if (pkt_count >= CHAN_FIRST && pkt_count <= CHAN_LAST) begin
            chan_store[pkt_count - CHAN_FIRST] = in_rf_byte;
          end
          if (pkt_count < POS_MAX) begin
            pkt_count = pkt_count + 4'd1;
          end
        end else begin
          if (pkt_count == RF_CRC_POS && sync_ok && in_rf_byte == pkt_crc) begin
            queue_rc_frame();
          end
          // every marked byte closes the packet, accepted or not
          pkt_count = 4'd0;
          pkt_crc = 8'h00;
          sync_ok = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected frame item: frame_byte %h frame_last %b",
                 out_frame_byte, out_frame_last);
          failures++;
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_frame_byte !== due.data) begin
            $error("frame_byte: expected %h, got %h", due.data, out_frame_byte);
            failures++;
          end
          if (out_frame_last !== due.last) begin
            $error("frame_last: expected %b, got %b", due.last, out_frame_last);
            failures++;
          end
        end
      end
    end
    pending = frame_bytes_due.size();
  end

endmodule

[verif/rf_control_packet_to_crsf_rc_frame_test.sv]
// Testbench top for the RF packet to RC frame encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module rf_control_packet_to_crsf_rc_frame_test;
  import rfcrsf_pkg::*;

  typedef enum int {
    PKT_GOOD,
    PKT_BAD_SYNC,
    PKT_BAD_CRC,
    PKT_SHORT,
    PKT_LONG
  } pkt_kind_t;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_BYTES = 47;
  localparam logic [15:0] CORNER_WORDS [8] = '{16'h0000, 16'h0001, 16'h07FE, 16'h07FF,
                                               16'h0800, 16'h7FFF, 16'h8000, 16'hFFFF};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rf_byte;
  logic       in_packet_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_frame_byte;
  logic       out_frame_last;

  int failures;
  int pending;
  int bytes_sent = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int hold_req = 0;
  int quiet = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rf_control_packet_to_crsf_rc_frame dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rf_byte     (in_rf_byte),
    .in_packet_end  (in_packet_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last)
  );

  rf_crsf_frame_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rf_byte     (in_rf_byte),
    .in_packet_end  (in_packet_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last),
    .failures       (failures),
    .pending        (pending)
  );

  // Offer one item at a falling edge and hold it until the block takes it.
  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rf_byte <= b;
    in_packet_end <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(2047));
      2: return 16'($urandom_range(2200, 1900));
      default: return CORNER_WORDS[$urandom_range(7)];
    endcase
  endfunction

  task automatic send_packet(input pkt_kind_t kind, input logic [15:0] w0, input logic [15:0] w1,
                             input logic [15:0] w2, input logic [15:0] w3);
    logic [7:0]  pkt [$];
    logic [15:0] words [4];
    logic [7:0]  crc;
    int          keep;
    words = '{w0, w1, w2, w3};
    pkt.push_back(SYNC_BYTE);
    pkt.push_back(8'($urandom_range(255)));
    pkt.push_back(8'($urandom_range(255)));
    foreach (words[i]) begin
      pkt.push_back(words[i][15:8]);
      pkt.push_back(words[i][7:0]);
    end
    if (kind == PKT_BAD_SYNC) begin
      pkt[0] = SYNC_BYTE ^ 8'($urandom_range(255, 1));
    end
    crc = 8'h00;
    foreach (pkt[i]) begin
      crc = rf_crc_step(crc, pkt[i]);
    end
    case (kind)
      PKT_BAD_CRC: crc = crc ^ 8'($urandom_range(255, 1));
      PKT_SHORT: begin
        keep = $urandom_range(10);
        while (pkt.size() > keep) begin
          void'(pkt.pop_back());
        end
        crc = 8'($urandom_range(255));
      end
      PKT_LONG: begin
        // a good packet body with trailing bytes; past 15 the count saturates
        pkt.push_back(crc);
        repeat ($urandom_range(8)) begin
          pkt.push_back(8'($urandom_range(255)));
        end
        crc = 8'($urandom_range(255));
      end
      default: ;
    endcase
    foreach (pkt[i]) begin
      send_item(pkt[i], 1'b0);
    end
    send_item(crc, 1'b1);
  endtask

  task automatic send_random_packet();
    int        r;
    pkt_kind_t kind;
    r = $urandom_range(99);
    if (r < 60) begin
      kind = PKT_GOOD;
    end else if (r < 70) begin
      kind = PKT_BAD_SYNC;
    end else if (r < 80) begin
      kind = PKT_BAD_CRC;
    end else if (r < 90) begin
      kind = PKT_SHORT;
    end else begin
      kind = PKT_LONG;
    end
    send_packet(kind, pick_word(), pick_word(), pick_word(), pick_word());
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("[rf_control_packet_to_crsf_rc_frame] ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rf_byte = 8'h00;
    in_packet_end = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // stick extremes, a lone marked byte, a full packet with a wrong sync byte
    send_packet(PKT_GOOD, 16'h0000, 16'h07FF, 16'h0800, 16'hFFFF);
    send_item(8'($urandom_range(255)), 1'b1);
    send_packet(PKT_BAD_SYNC, pick_word(), pick_word(), pick_word(), pick_word());

    // hold the output off while good packets keep coming, so the input backs up
    hold_req++;
    repeat (3) begin
      send_packet(PKT_GOOD, pick_word(), pick_word(), pick_word(), pick_word());
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 59; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 59; end
        default: begin in_gap_pct = 21; out_stall_pct = 21; end
      endcase
      while (bytes_sent < 25 + PHASE_BYTES * (ph + 1)) begin
        send_random_packet();
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("[rf_control_packet_to_crsf_rc_frame] OK");
    end else begin
      $display("[rf_control_packet_to_crsf_rc_frame] ERROR");
    end
    $finish;
  end

endmodule

[rf_control_packet_to_crsf_rc_frame.f]
sv/rfcrsf_pkg.sv
sv/rfcrsf_ctrl.sv
sv/rfcrsf_dp.sv
sv/rf_control_packet_to_crsf_rc_frame.sv
verif/rf_crsf_frame_checker.sv
verif/rf_control_packet_to_crsf_rc_frame_test.sv
